[sv/fscw_pkg.sv]
// ----------------------------------------------------------------------------
// fscw_pkg: shared definitions for the sector chain walker
// Table depths, function codes, status codes, register indexes, sentinels, shift limits and reset values.
// ----------------------------------------------------------------------------
package fscw_pkg;

   // Table depths.
   localparam int FAT_DEPTH_DEFAULT  = 32;
   localparam int MINI_DEPTH_DEFAULT = 32;

   // Request function codes.
   localparam logic [1:0] FUNC_LOAD_FAT  = 2'd0;
   localparam logic [1:0] FUNC_LOAD_MINI = 2'd1;
   localparam logic [1:0] FUNC_READ      = 2'd2;

   // Result status codes.
   localparam logic [2:0] STAT_SECTOR = 3'd0;
   localparam logic [2:0] STAT_DONE   = 3'd1;
   localparam logic [2:0] STAT_INDEX  = 3'd2;
   localparam logic [2:0] STAT_CAP    = 3'd3;
   localparam logic [2:0] STAT_BOUNDS = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_SECTOR_SHIFT  = 3'd0;
   localparam logic [2:0] CSR_FILE_LENGTH   = 3'd1;
   localparam logic [2:0] CSR_FAT_ENTRIES   = 3'd2;
   localparam logic [2:0] CSR_MINI_ENTRIES  = 3'd3;
   localparam logic [2:0] CSR_MINI_LENGTH   = 3'd4;
   localparam logic [2:0] CSR_SIZE_SPLIT    = 3'd5;

   // Chain sentinels and fixed sizes.
   localparam logic [31:0] SECT_FREE  = 32'hFFFF_FFFF;
   localparam logic [31:0] SECT_END   = 32'hFFFF_FFFE;
   localparam logic [31:0] HDR_BYTES  = 32'd512;
   localparam logic [31:0] MINI_BYTES = 32'd64;

   // Shift clamp limits.
   localparam logic [3:0] SHIFT_MIN = 4'd9;
   localparam logic [3:0] SHIFT_MAX = 4'd12;

   // Register reset values.
   localparam logic [3:0]  RST_SECTOR_SHIFT = 4'd9;
   localparam logic [31:0] RST_SIZE_SPLIT   = 32'd4096;

endpackage

[sv/fscw_ram.sv]
// ----------------------------------------------------------------------------
// fscw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module fscw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/fat_sector_chain_walker_unit.sv]
// ----------------------------------------------------------------------------
// fat_sector_chain_walker_unit: allocation chain walker
// Holds a regular and a mini allocation table and walks a chain from a start
// sector, giving one offset word per sector and a terminal status word.
// ----------------------------------------------------------------------------
// An accepted read moves the sequencer to the walk state; each result word is registered in the output register.
// Throughput: one result word per cycle while rsp_tready stays high, bounded by
// the single registered read port of each table; requests, loads included, are
// only accepted while no walk is in progress.
// Reset: synchronous; clears the sequencer, output valid and the registers to
// their reset values. Table contents are not cleared.
module fat_sector_chain_walker_unit #(
   parameter int FAT_DEPTH  = fscw_pkg::FAT_DEPTH_DEFAULT,
   parameter int MINI_DEPTH = fscw_pkg::MINI_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // Configuration write port.
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // entry_index[4:0], entry_value[36:5], start_sector[68:37],
   // stream_size[100:69], zero fill [103:101]
   input  logic [103:0] req_tdata,
   // func[1:0]
   input  logic [1:0]   req_tuser,
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // byte_offset[31:0], chunk_bytes[44:32], pad_bytes[76:45], zero fill [79:77]
   output logic [79:0]  rsp_tdata,
   // from_mini[0], status[3:1]
   output logic [3:0]   rsp_tuser,
   output logic         rsp_tlast
);

   localparam int FAT_AW  = (FAT_DEPTH > 1) ? $clog2(FAT_DEPTH) : 1;
   localparam int MINI_AW = (MINI_DEPTH > 1) ? $clog2(MINI_DEPTH) : 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   // Request fields.
   logic [1:0]  req_func;
   logic [4:0]  req_index;
   logic [31:0] req_value;
   logic [31:0] req_start;
   logic [31:0] req_size;
   logic        req_fire;

   assign req_func  = req_tuser;
   assign req_index = req_tdata[4:0];
   assign req_value = req_tdata[36:5];
   assign req_start = req_tdata[68:37];
   assign req_size  = req_tdata[100:69];
   assign req_fire  = req_tvalid && req_tready;

   // Configuration registers.
   logic [3:0]  sector_shift_ff;
   logic [31:0] file_length_ff;
   logic [5:0]  fat_entries_ff;
   logic [5:0]  mini_entries_ff;
   logic [31:0] mini_length_ff;
   logic [31:0] size_split_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_shift_ff <= fscw_pkg::RST_SECTOR_SHIFT;
         file_length_ff  <= '0;
         fat_entries_ff  <= '0;
         mini_entries_ff <= '0;
         mini_length_ff  <= '0;
         size_split_ff   <= fscw_pkg::RST_SIZE_SPLIT;
      end else if (csr_we) begin
         case (csr_addr)
            fscw_pkg::CSR_SECTOR_SHIFT: sector_shift_ff <= csr_wdata[3:0];
            fscw_pkg::CSR_FILE_LENGTH:  file_length_ff  <= csr_wdata;
            fscw_pkg::CSR_FAT_ENTRIES:  fat_entries_ff  <= csr_wdata[5:0];
            fscw_pkg::CSR_MINI_ENTRIES: mini_entries_ff <= csr_wdata[5:0];
            fscw_pkg::CSR_MINI_LENGTH:  mini_length_ff  <= csr_wdata;
            fscw_pkg::CSR_SIZE_SPLIT:   size_split_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer and walk state.
   logic        state_ff, state_in;
   logic [31:0] cur_sector_ff, cur_sector_in;
   logic        from_ram_ff, from_ram_in;
   logic        mini_ff, mini_in;
   logic [6:0]  step_ff, step_in;
   logic [31:0] remain_ff, remain_in;

   // Output register.
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_offset_ff, out_offset_in;
   logic [12:0] out_chunk_ff, out_chunk_in;
   logic [31:0] out_pad_ff, out_pad_in;
   logic        out_mini_ff, out_mini_in;
   logic [2:0]  out_status_ff, out_status_in;
   logic        out_last_ff, out_last_in;

   // Table ports.
   logic [5:0]          wr_index;
   logic                fat_wr_en, mini_wr_en;
   logic                fat_rd_en, mini_rd_en;
   logic [31:0]         fat_rd_data, mini_rd_data;

   assign wr_index   = {1'b0, req_index};
   assign fat_wr_en  = req_fire && (req_func == fscw_pkg::FUNC_LOAD_FAT)
                       && ({1'b0, wr_index} < 7'(FAT_DEPTH));
   assign mini_wr_en = req_fire && (req_func == fscw_pkg::FUNC_LOAD_MINI)
                       && ({1'b0, wr_index} < 7'(MINI_DEPTH));

   // Step datapath.
   logic        out_free;
   logic        advance;
   logic [31:0] sect;
   logic [5:0]  count;
   logic [3:0]  shift;
   logic [12:0] ssize;
   logic [31:0] reg_off;
   logic [31:0] reg_end;
   logic [31:0] mini_off;
   logic [31:0] mini_end;
   logic [6:0]  mini_n;
   logic [6:0]  step_inc;
   logic        term_end;
   logic        idx_fault;
   logic        cap_fault;
   logic        bound_fault;

   assign out_free = !out_valid_ff || rsp_tready;
   assign advance  = (state_ff == ST_WALK) && out_free;

   always_comb begin
      if (from_ram_ff) begin
         sect = mini_ff ? mini_rd_data : fat_rd_data;
      end else begin
         sect = cur_sector_ff;
      end

      if (mini_ff) begin
         count = (mini_entries_ff > 6'(MINI_DEPTH)) ? 6'(MINI_DEPTH) : mini_entries_ff;
      end else begin
         count = (fat_entries_ff > 6'(FAT_DEPTH)) ? 6'(FAT_DEPTH) : fat_entries_ff;
      end

      if (sector_shift_ff < fscw_pkg::SHIFT_MIN) begin
         shift = fscw_pkg::SHIFT_MIN;
      end else if (sector_shift_ff > fscw_pkg::SHIFT_MAX) begin
         shift = fscw_pkg::SHIFT_MAX;
      end else begin
         shift = sector_shift_ff;
      end
      ssize = 13'd1 << shift;

      // Offsets are only used once the sector is known to be below the
      // entry count, so six sector bits cover them.
      reg_off  = fscw_pkg::HDR_BYTES + (32'(sect[5:0]) << shift);
      reg_end  = reg_off + 32'(ssize);
      mini_off = {20'd0, sect[5:0], 6'd0};
      mini_end = mini_off + fscw_pkg::MINI_BYTES;
      mini_n   = (remain_ff > fscw_pkg::MINI_BYTES) ? 7'd64 : remain_ff[6:0];
      step_inc = step_ff + 7'd1;

      term_end    = (sect == fscw_pkg::SECT_END) || (sect == fscw_pkg::SECT_FREE)
                    || (mini_ff && (remain_ff == '0));
      idx_fault   = sect >= {26'd0, count};
      cap_fault   = step_inc > ({1'b0, count} + 7'd1);
      bound_fault = mini_ff ? (mini_end > mini_length_ff) : (reg_end > file_length_ff);
   end

   always_comb begin
      state_in      = state_ff;
      cur_sector_in = cur_sector_ff;
      from_ram_in   = from_ram_ff;
      mini_in       = mini_ff;
      step_in       = step_ff;
      remain_in     = remain_ff;
      fat_rd_en     = 1'b0;
      mini_rd_en    = 1'b0;

      out_valid_in  = out_valid_ff && !rsp_tready;
      out_offset_in = out_offset_ff;
      out_chunk_in  = out_chunk_ff;
      out_pad_in    = out_pad_ff;
      out_mini_in   = out_mini_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_func == fscw_pkg::FUNC_READ)) begin
               state_in      = ST_WALK;
               cur_sector_in = req_start;
               from_ram_in   = 1'b0;
               mini_in       = req_size < size_split_ff;
               step_in       = '0;
               remain_in     = req_size;
            end
         end
         ST_WALK: begin
            if (advance) begin
               out_valid_in  = 1'b1;
               out_mini_in   = mini_ff;
               out_offset_in = '0;
               out_chunk_in  = '0;
               out_pad_in    = '0;
               out_last_in   = 1'b1;
               if (term_end) begin
                  out_status_in = fscw_pkg::STAT_DONE;
                  out_pad_in    = mini_ff ? remain_ff : '0;
               end else if (idx_fault) begin
                  out_status_in = fscw_pkg::STAT_INDEX;
               end else if (cap_fault) begin
                  out_status_in = fscw_pkg::STAT_CAP;
               end else if (bound_fault) begin
                  out_status_in = fscw_pkg::STAT_BOUNDS;
               end else begin
                  // Valid sector: emit it and fetch the next link.
                  out_status_in = fscw_pkg::STAT_SECTOR;
                  out_last_in   = 1'b0;
                  out_offset_in = mini_ff ? mini_off : reg_off;
                  out_chunk_in  = mini_ff ? {6'd0, mini_n} : ssize;
                  step_in       = step_inc;
                  remain_in     = remain_ff - {25'd0, mini_n};
                  from_ram_in   = 1'b1;
                  fat_rd_en     = !mini_ff;
                  mini_rd_en    = mini_ff;
               end
               if (out_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_sector_ff <= '0;
         out_valid_ff  <= 1'b0;
         from_ram_ff   <= 1'b0;
         mini_ff       <= 1'b0;
         step_ff       <= '0;
         remain_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         cur_sector_ff <= cur_sector_in;
         out_valid_ff  <= out_valid_in;
         from_ram_ff   <= from_ram_in;
         mini_ff       <= mini_in;
         step_ff       <= step_in;
         remain_ff     <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      out_offset_ff <= out_offset_in;
      out_chunk_ff  <= out_chunk_in;
      out_pad_ff    <= out_pad_in;
      out_mini_ff   <= out_mini_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   fscw_ram #(
      .WIDTH (32),
      .DEPTH (FAT_DEPTH),
      .AW    (FAT_AW)
   ) u_fat_ram (
      .clock   (clock),
      .wr_en   (fat_wr_en),
      .wr_addr (wr_index[FAT_AW-1:0]),
      .wr_data (req_value),
      .rd_en   (fat_rd_en),
      .rd_addr (sect[FAT_AW-1:0]),
      .rd_data (fat_rd_data)
   );

   fscw_ram #(
      .WIDTH (32),
      .DEPTH (MINI_DEPTH),
      .AW    (MINI_AW)
   ) u_mini_ram (
      .clock   (clock),
      .wr_en   (mini_wr_en),
      .wr_addr (wr_index[MINI_AW-1:0]),
      .wr_data (req_value),
      .rd_en   (mini_rd_en),
      .rd_addr (sect[MINI_AW-1:0]),
      .rd_data (mini_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_pad_ff, out_chunk_ff, out_offset_ff};
   assign rsp_tuser  = {out_status_ff, out_mini_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef NO_ASSERTIONS
   // A read request always starts a walk on the next cycle.
   a_read_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_func == fscw_pkg::FUNC_READ)) |=> (state_ff == ST_WALK))
      else $error("read request did not start a walk");

   // Loading a terminal word ends the walk.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (advance && out_last_in) |=> (state_ff == ST_IDLE))
      else $error("walk continued after terminal word");

   // The step counter never passes the cap during a walk.
   a_step_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (step_ff <= ({1'b0, count} + 7'd1)))
      else $error("step counter beyond cap");

   // A terminal word carries no offset and no chunk.
   a_last_empty: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> ((out_offset_ff == '0) && (out_chunk_ff == '0)))
      else $error("terminal word has offset or chunk");
`endif

endmodule
